/* hw/rtl/block_average_mosaic_macros.svh */
// ----------------------------------------------------------------------------
// block_average_mosaic_macros
// assertion macros shared by the mosaic block
// ----------------------------------------------------------------------------
`ifndef BLOCK_AVERAGE_MOSAIC_MACROS_SVH
`define BLOCK_AVERAGE_MOSAIC_MACROS_SVH

// same-cycle implication, checked outside reset
`define BAM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define BAM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/bam_pkg.sv */
// ----------------------------------------------------------------------------
// bam_pkg
// shared constants and types of the mosaic block
// ----------------------------------------------------------------------------
package bam_pkg;

	localparam int SIDE       = 64;
	localparam int COORD_W    = $clog2(SIDE);
	localparam int ADDR_W     = 2 * COORD_W;
	localparam int CHAN_W     = 8;
	localparam int PIX_W      = 3 * CHAN_W;
	localparam int BS_W       = 7;
	localparam int ORG_W      = BS_W + 1;
	localparam int CNT_W      = ADDR_W + 1;
	localparam int SUM_W      = CHAN_W + ADDR_W;
	localparam int REM_W      = CNT_W + 1;
	localparam int ORG_STEPS  = COORD_W;
	localparam int QUOT_STEPS = SUM_W;
	localparam int STEP_W     = $clog2(QUOT_STEPS);

	localparam logic [BS_W-1:0] BS_RESET = BS_W'(5);

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef struct packed {
		logic wr;
		logic capture;
		logic org_step;
		logic org_done;
		logic walk;
		logic quot_load;
		logic quot_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic walk_last;
	} status_t;

endpackage

/* hw/rtl/bam_ctrl.sv */
// ----------------------------------------------------------------------------
// bam_ctrl
// sequencer for load and read items of the mosaic block
// ----------------------------------------------------------------------------
module bam_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             mode,
	output logic             in_ready,
	input  logic             out_ready,
	output logic             out_valid,
	input  bam_pkg::status_t status,
	output bam_pkg::cmd_t    cmd
);
	import bam_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ORIGIN,
		ST_SETUP,
		ST_WALK,
		ST_DRAIN,
		ST_QLOAD,
		ST_QUOT,
		ST_EMIT
	} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;
	logic                accept;
	logic                emit_ok;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign emit_ok   = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		cmd           = '0;
		cmd.capture   = accept;
		cmd.wr        = accept && (mode == MODE_LOAD);
		cmd.org_step  = (state_q == ST_ORIGIN);
		cmd.org_done  = (state_q == ST_SETUP);
		cmd.walk      = (state_q == ST_WALK);
		cmd.quot_load = (state_q == ST_QLOAD);
		cmd.quot_step = (state_q == ST_QUOT);
		cmd.out_load  = emit_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (accept && (mode == MODE_READ)) begin
						state_q <= ST_ORIGIN;
					end
				end
				ST_ORIGIN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(ORG_STEPS - 1)) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (status.walk_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_QLOAD;
				end
				ST_QLOAD: begin
					step_q  <= '0;
					state_q <= ST_QUOT;
				end
				ST_QUOT: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(QUOT_STEPS - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/bam_dp.sv */
// ----------------------------------------------------------------------------
// bam_dp
// pixel store, tile origin, tile walk, accumulators and mean divider
// ----------------------------------------------------------------------------
module bam_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bam_pkg::cmd_t                 cmd,
	output bam_pkg::status_t              status,
	input  logic [bam_pkg::BS_W-1:0]      block_size,
	input  logic [bam_pkg::COORD_W-1:0]   pos_x,
	input  logic [bam_pkg::COORD_W-1:0]   pos_y,
	input  logic [bam_pkg::CHAN_W-1:0]    in_red,
	input  logic [bam_pkg::CHAN_W-1:0]    in_green,
	input  logic [bam_pkg::CHAN_W-1:0]    in_blue,
	output logic [bam_pkg::CHAN_W-1:0]    avg_red,
	output logic [bam_pkg::CHAN_W-1:0]    avg_green,
	output logic [bam_pkg::CHAN_W-1:0]    avg_blue
);
	import bam_pkg::*;

	// one restoring division step: {remainder, shifted dividend with quotient bit}
	function automatic logic [REM_W+SUM_W-1:0] div_step(
		input logic [REM_W-1:0] rem,
		input logic [SUM_W-1:0] dvd,
		input logic [CNT_W-1:0] dvs
	);
		logic [REM_W-1:0] t;
		logic             ge;
		t  = {rem[REM_W-2:0], dvd[SUM_W-1]};
		ge = (t >= {1'b0, dvs});
		return {(ge ? t - {1'b0, dvs} : t), dvd[SUM_W-2:0], ge};
	endfunction

	// remainder step of a coordinate by the tile size
	function automatic logic [ORG_W-1:0] org_rem(
		input logic [ORG_W-1:0] rem,
		input logic             bit_in,
		input logic [BS_W-1:0]  bs
	);
		logic [ORG_W-1:0] t;
		t = {rem[ORG_W-2:0], bit_in};
		return (t >= {1'b0, bs}) ? t - {1'b0, bs} : t;
	endfunction

	// last coordinate of a tile, clipped at the image edge
	function automatic logic [COORD_W-1:0] tile_last(
		input logic [COORD_W-1:0] org,
		input logic [BS_W-1:0]    bs
	);
		logic [ORG_W:0] e;
		e = {{(ORG_W+1-COORD_W){1'b0}}, org} + {2'b00, bs};
		return (e >= (ORG_W+1)'(SIDE)) ? COORD_W'(SIDE - 1) : COORD_W'(e - 1'b1);
	endfunction

	logic [PIX_W-1:0]   mem [SIDE*SIDE];
	logic [PIX_W-1:0]   rd_px_s1;
	logic               rd_v_s1;

	logic [COORD_W-1:0] x_q, y_q, xs_q, ys_q;
	logic [ORG_W-1:0]   rx_q, ry_q;
	logic [BS_W-1:0]    bs_q;
	logic [COORD_W-1:0] m_q, n_q, xb_q, xl_q, yl_q;
	logic [COORD_W-1:0] x0, y0;

	logic [SUM_W-1:0]   sr_q, sg_q, sb_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W-1:0]   dr_q, dg_q, db_q;
	logic [REM_W-1:0]   rr_q, rg_q, rb_q;
	logic [CHAN_W-1:0]  avg_r_q, avg_g_q, avg_b_q;

	assign x0 = x_q - rx_q[COORD_W-1:0];
	assign y0 = y_q - ry_q[COORD_W-1:0];

	assign status.walk_last = (m_q == xl_q) && (n_q == yl_q);

	assign avg_red   = avg_r_q;
	assign avg_green = avg_g_q;
	assign avg_blue  = avg_b_q;

	// pixel store, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[{pos_y, pos_x}] <= {in_red, in_green, in_blue};
		end
		rd_px_s1 <= mem[{n_q, m_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.walk;
		end
	end

	// tile origin and walk
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q  <= pos_x;
			y_q  <= pos_y;
			xs_q <= pos_x;
			ys_q <= pos_y;
			rx_q <= '0;
			ry_q <= '0;
			bs_q <= (block_size == '0) ? BS_W'(1) : block_size;
		end
		if (cmd.org_step) begin
			rx_q <= org_rem(rx_q, xs_q[COORD_W-1], bs_q);
			ry_q <= org_rem(ry_q, ys_q[COORD_W-1], bs_q);
			xs_q <= {xs_q[COORD_W-2:0], 1'b0};
			ys_q <= {ys_q[COORD_W-2:0], 1'b0};
		end
		if (cmd.org_done) begin
			m_q  <= x0;
			n_q  <= y0;
			xb_q <= x0;
			xl_q <= tile_last(x0, bs_q);
			yl_q <= tile_last(y0, bs_q);
		end
		if (cmd.walk) begin
			if (m_q == xl_q) begin
				m_q <= xb_q;
				n_q <= n_q + 1'b1;
			end else begin
				m_q <= m_q + 1'b1;
			end
		end
	end

	// channel sums and pixel count
	always_ff @(posedge clk) begin
		if (cmd.org_done) begin
			sr_q  <= '0;
			sg_q  <= '0;
			sb_q  <= '0;
			cnt_q <= '0;
		end else if (rd_v_s1) begin
			sr_q  <= sr_q + SUM_W'(rd_px_s1[3*CHAN_W-1:2*CHAN_W]);
			sg_q  <= sg_q + SUM_W'(rd_px_s1[2*CHAN_W-1:CHAN_W]);
			sb_q  <= sb_q + SUM_W'(rd_px_s1[CHAN_W-1:0]);
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// shared-count restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.quot_load) begin
			dr_q <= sr_q;
			dg_q <= sg_q;
			db_q <= sb_q;
			rr_q <= '0;
			rg_q <= '0;
			rb_q <= '0;
		end else if (cmd.quot_step) begin
			{rr_q, dr_q} <= div_step(rr_q, dr_q, cnt_q);
			{rg_q, dg_q} <= div_step(rg_q, dg_q, cnt_q);
			{rb_q, db_q} <= div_step(rb_q, db_q, cnt_q);
		end
		if (cmd.out_load) begin
			avg_r_q <= dr_q[CHAN_W-1:0];
			avg_g_q <= dg_q[CHAN_W-1:0];
			avg_b_q <= db_q[CHAN_W-1:0];
		end
	end

endmodule

/* hw/rtl/block_average_mosaic.sv */
// ----------------------------------------------------------------------------
// block_average_mosaic
// mosaic pixelation of a 64 by 64 rgb image by tile average
// ----------------------------------------------------------------------------
// a load item (mode 0) writes one pixel into the 4096-entry pixel store
// and gives no result; loads can follow each other every cycle while no
// read is in progress. a read item (mode 1) gives one result: the truncated
// mean of each channel over the block_size square tile, aligned to
// multiples of block_size, that holds the point, clipped at the image edge.
// a read loads the output register, when it is free, after these steps,
// with w*h the pixel count of the clipped tile: the origin state finds the
// tile origin bit by bit, the setup state sets up the walk, the tile walk
// reads its w*h pixels, one a cycle, through the single store read port,
// the drain and qload states drain the read and load the divider, a
// restoring divider turns the three sums into means and the emit state
// hands them to the output register. the input reopens in the cycle after
// that. a finished result waits in the output register while the next item
// is accepted. block_size sits at byte address 0 of the apb port, resets to
// 5, and a value of 0 acts as 1. pixels of a tile must all be loaded before it is read.
// ----------------------------------------------------------------------------
`include "block_average_mosaic_macros.svh"

module block_average_mosaic (
	input  logic                          clk,
	input  logic                          arst_n,
	// apb configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// item input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic [bam_pkg::COORD_W-1:0]   pos_x,
	input  logic [bam_pkg::COORD_W-1:0]   pos_y,
	input  logic [bam_pkg::CHAN_W-1:0]    in_red,
	input  logic [bam_pkg::CHAN_W-1:0]    in_green,
	input  logic [bam_pkg::CHAN_W-1:0]    in_blue,
	// result output
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bam_pkg::CHAN_W-1:0]    avg_red,
	output logic [bam_pkg::CHAN_W-1:0]    avg_green,
	output logic [bam_pkg::CHAN_W-1:0]    avg_blue
);
	import bam_pkg::*;

	logic [BS_W-1:0] block_size_q;
	logic            reg_sel;
	cmd_t            cmd;
	status_t         status;

	// word 0 holds block_size, word 1 reads as zero
	assign reg_sel = (paddr[2] == 1'b0);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {{(32-BS_W){1'b0}}, block_size_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= BS_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			block_size_q <= pwdata[BS_W-1:0];
		end
	end

	// sequencer
	bam_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.mode      (mode),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.status    (status),
		.cmd       (cmd)
	);

	// store, walk, sums and divider
	bam_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.block_size (block_size_q),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.in_red     (in_red),
		.in_green   (in_green),
		.in_blue    (in_blue),
		.avg_red    (avg_red),
		.avg_green  (avg_green),
		.avg_blue   (avg_blue)
	);

	// a read item keeps the input closed while it works
	`BAM_ASSERT_NEXT(a_read_blocks_input, in_valid && in_ready && (mode == MODE_READ), !in_ready, "read item did not close the input")

	// a new result only appears at the end of a read
	`BAM_ASSERT_SAME(a_result_from_emit, $rose(out_valid), $past(!in_ready), "result appeared without a read in progress")

	// a register write lands in block_size
	`BAM_ASSERT_NEXT(a_cfg_write, psel && penable && pwrite && reg_sel, block_size_q == $past(pwdata[BS_W-1:0]), "block_size write lost")

endmodule
